@@ src/fpaf_pkg.sv @@
// shared types, constants and helpers for the fixed-point ascii formatter
package fpaf_pkg;

    // binary width fed into the conversion chain and bcd width coming out
    localparam int BIN_W     = 17;
    localparam int DIGITS    = 5;
    localparam int BCD_W     = 4 * DIGITS;
    localparam int NUM_CELLS = BIN_W;

    localparam int CHAR_W = 7;
    localparam int MODE_W = 2;

    // format mode codes
    localparam logic [MODE_W-1:0] FMT_UDEC2 = 2'd0;
    localparam logic [MODE_W-1:0] FMT_SDEC3 = 2'd1;
    localparam logic [MODE_W-1:0] FMT_UBIN8 = 2'd2;

    // range limits
    localparam logic [31:0] UDEC2_MAX = 32'd99999;
    localparam logic [31:0] SDEC3_MAX = 32'd9999;
    localparam logic [31:0] UBIN8_MAX = 32'd255999;

    // ascii codes
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CH_STAR  = 7'h2A;
    localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2E;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 7'h39;

    // per-request side information that rides along the chain
    typedef struct packed {
        logic sdec;     // signed decimal layout
        logic neg;      // value was negative
        logic oor;      // out of range, show asterisks
    } side_t;

    // data held in each conversion cell
    typedef struct packed {
        logic [BCD_W-1:0] bcd;
        logic [BIN_W-1:0] bin;
        side_t            side;
    } cell_t;

    // decimal digit to ascii
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        digit_char = {3'b011, d};
    endfunction

endpackage

@@ src/fixed_point_ascii_formatter.sv @@
// top level: format register, input stage, bcd cell chain and output stage
// path: a request accepted into the input stage register passes through 17
//   shift-and-add-3 cells and the output register before it shows on m_valid
// throughput: one request per cycle while m_ready stays high; each stage holds
//   one request and moves it on whenever the next stage is empty or draining
// reset: aresetn is synchronous, active low; clears all stage valids and sets
//   format_mode to 0
module fixed_point_ascii_formatter
    import fpaf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [31:0]       s_value_word,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAR_W-1:0] m_char_0,
    output logic [CHAR_W-1:0] m_char_1,
    output logic [CHAR_W-1:0] m_char_2,
    output logic [CHAR_W-1:0] m_char_3,
    output logic [CHAR_W-1:0] m_char_4,
    output logic [CHAR_W-1:0] m_char_5,
    output logic              m_out_of_range,
    input  logic              cfg_wr_en,
    input  logic [MODE_W-1:0] cfg_wr_data
);

    logic [MODE_W-1:0] format_mode_reg;

    cell_t chain_data  [NUM_CELLS+1];
    logic  chain_valid [NUM_CELLS+1];
    logic  chain_ready [NUM_CELLS+1];

    // format mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_mode_reg <= FMT_UDEC2;
        end else if (cfg_wr_en) begin
            format_mode_reg <= cfg_wr_data;
        end
    end

    // input stage
    fpaf_prep u_prep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .value_word (s_value_word),
        .fmt_mode   (format_mode_reg),
        .out_valid  (chain_valid[0]),
        .out_ready  (chain_ready[0]),
        .out_data   (chain_data[0])
    );

    // binary to bcd cell chain, one bit per cell
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        fpaf_dd_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_data   (chain_data[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_data  (chain_data[g+1])
        );
    end

    // output stage
    fpaf_format u_format (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (chain_valid[NUM_CELLS]),
        .in_ready       (chain_ready[NUM_CELLS]),
        .in_data        (chain_data[NUM_CELLS]),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_char_0       (m_char_0),
        .m_char_1       (m_char_1),
        .m_char_2       (m_char_2),
        .m_char_3       (m_char_3),
        .m_char_4       (m_char_4),
        .m_char_5       (m_char_5),
        .m_out_of_range (m_out_of_range)
    );

endmodule

@@ src/fpaf_prep.sv @@
// input stage: range check, sign handling and binary value for the bcd chain
module fpaf_prep
    import fpaf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [31:0]       value_word,
    input  logic [MODE_W-1:0] fmt_mode,
    output logic              out_valid,
    input  logic              out_ready,
    output cell_t             out_data
);

    logic        valid_reg;
    cell_t       data_reg;
    cell_t       data_next;

    logic [31:0]      mag;
    logic [7:0]       frac_byte;
    logic [12:0]      frac_prod;
    logic [6:0]       frac_dec;
    logic [BIN_W-1:0] ubin_val;

    // signed magnitude and binary fraction scaling
    always_comb begin
        mag       = value_word[31] ? (32'd0 - value_word) : value_word;
        frac_byte = (value_word[7:0] == 8'hFF) ? 8'hFE : value_word[7:0];
        frac_prod = {5'd0, frac_byte} * 13'd25;
        frac_dec  = frac_prod[12:6];
        ubin_val  = {7'd0, value_word[17:8]} * 17'd100 + {10'd0, frac_dec};
    end

    // per-mode setup of the chain input
    always_comb begin
        data_next.bcd = '0;
        unique case (fmt_mode)
            FMT_UDEC2: begin
                data_next.bin       = value_word[BIN_W-1:0];
                data_next.side.sdec = 1'b0;
                data_next.side.neg  = 1'b0;
                data_next.side.oor  = value_word > UDEC2_MAX;
            end
            FMT_SDEC3: begin
                data_next.bin       = {3'd0, mag[13:0]};
                data_next.side.sdec = 1'b1;
                data_next.side.neg  = value_word[31];
                data_next.side.oor  = mag > SDEC3_MAX;
            end
            FMT_UBIN8: begin
                data_next.bin       = ubin_val;
                data_next.side.sdec = 1'b0;
                data_next.side.neg  = 1'b0;
                data_next.side.oor  = value_word > UBIN8_MAX;
            end
            default: begin
                // unused code behaves as the binary format
                data_next.bin       = ubin_val;
                data_next.side.sdec = 1'b0;
                data_next.side.neg  = 1'b0;
                data_next.side.oor  = value_word > UBIN8_MAX;
            end
        endcase
    end

    // stage handshake
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ src/fpaf_dd_cell.sv @@
// one shift-and-add-3 cell of the binary to bcd chain
module fpaf_dd_cell
    import fpaf_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  cell_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output cell_t out_data
);

    logic             valid_reg;
    cell_t            data_reg;
    cell_t            data_next;
    logic [BCD_W-1:0] bcd_adj;

    // add 3 to every digit of 5 or more, then shift in the next binary bit
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            bcd_adj[4*i +: 4] = (in_data.bcd[4*i +: 4] >= 4'd5) ?
                                (in_data.bcd[4*i +: 4] + 4'd3) : in_data.bcd[4*i +: 4];
        end
        data_next.bcd  = {bcd_adj[BCD_W-2:0], in_data.bin[BIN_W-1]};
        data_next.bin  = {in_data.bin[BIN_W-2:0], 1'b0};
        data_next.side = in_data.side;
    end

    // stage handshake
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // every digit leaving a cell stays a decimal digit
    a_digits_decimal: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (data_reg.bcd[3:0] <= 4'd9) && (data_reg.bcd[7:4] <= 4'd9) &&
                      (data_reg.bcd[11:8] <= 4'd9) && (data_reg.bcd[15:12] <= 4'd9) &&
                      (data_reg.bcd[19:16] <= 4'd9))
        else $error("bcd digit above nine in conversion cell");

endmodule

@@ src/fpaf_format.sv @@
// output stage: digits to ascii characters, held in the output register
module fpaf_format
    import fpaf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  cell_t             in_data,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAR_W-1:0] m_char_0,
    output logic [CHAR_W-1:0] m_char_1,
    output logic [CHAR_W-1:0] m_char_2,
    output logic [CHAR_W-1:0] m_char_3,
    output logic [CHAR_W-1:0] m_char_4,
    output logic [CHAR_W-1:0] m_char_5,
    output logic              m_out_of_range
);

    logic              valid_reg;
    logic [CHAR_W-1:0] chars_reg  [6];
    logic [CHAR_W-1:0] chars_next [6];
    logic              oor_reg;
    logic [3:0]        d4, d3, d2, d1, d0;

    assign d4 = in_data.bcd[19:16];
    assign d3 = in_data.bcd[15:12];
    assign d2 = in_data.bcd[11:8];
    assign d1 = in_data.bcd[7:4];
    assign d0 = in_data.bcd[3:0];

    // character layout per format
    always_comb begin
        priority if (in_data.side.oor && in_data.side.sdec) begin
            chars_next[0] = CH_SPACE;
            chars_next[1] = CH_STAR;
            chars_next[2] = CH_DOT;
            chars_next[3] = CH_STAR;
            chars_next[4] = CH_STAR;
            chars_next[5] = CH_STAR;
        end else if (in_data.side.oor) begin
            chars_next[0] = CH_STAR;
            chars_next[1] = CH_STAR;
            chars_next[2] = CH_STAR;
            chars_next[3] = CH_DOT;
            chars_next[4] = CH_STAR;
            chars_next[5] = CH_STAR;
        end else if (in_data.side.sdec) begin
            chars_next[0] = in_data.side.neg ? CH_MINUS : CH_SPACE;
            chars_next[1] = digit_char(d3);
            chars_next[2] = CH_DOT;
            chars_next[3] = digit_char(d2);
            chars_next[4] = digit_char(d1);
            chars_next[5] = digit_char(d0);
        end else begin
            // decimal and binary formats share the blanked ddd.dd layout
            chars_next[0] = (d4 == 4'd0) ? CH_SPACE : digit_char(d4);
            chars_next[1] = (d4 == 4'd0 && d3 == 4'd0) ? CH_SPACE : digit_char(d3);
            chars_next[2] = digit_char(d2);
            chars_next[3] = CH_DOT;
            chars_next[4] = digit_char(d1);
            chars_next[5] = digit_char(d0);
        end
    end

    // output register handshake
    assign in_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            chars_reg <= chars_next;
            oor_reg   <= in_data.side.oor;
        end
    end

    assign m_valid        = valid_reg;
    assign m_char_0       = chars_reg[0];
    assign m_char_1       = chars_reg[1];
    assign m_char_2       = chars_reg[2];
    assign m_char_3       = chars_reg[3];
    assign m_char_4       = chars_reg[4];
    assign m_char_5       = chars_reg[5];
    assign m_out_of_range = oor_reg;

    // a decimal point sits in the third or fourth place
    a_dot_place: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_char_2 == CH_DOT) || (m_char_3 == CH_DOT))
        else $error("decimal point missing from result");

    // asterisks end every out-of-range result
    a_oor_stars: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_of_range |-> (m_char_5 == CH_STAR) && (m_char_4 == CH_STAR))
        else $error("out-of-range result without asterisks");

    // an in-range result ends in a digit
    a_last_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_out_of_range |-> (m_char_5 >= CH_ZERO) && (m_char_5 <= CH_NINE))
        else $error("in-range result does not end in a digit");

endmodule

@@ test/display_checker.sv @@
// checker for the ascii formatter: predicts each display field and compares results
`timescale 1ns / 100ps
module display_checker
    import fpaf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [31:0]       s_value_word,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [CHAR_W-1:0] m_char_0,
    input  logic [CHAR_W-1:0] m_char_1,
    input  logic [CHAR_W-1:0] m_char_2,
    input  logic [CHAR_W-1:0] m_char_3,
    input  logic [CHAR_W-1:0] m_char_4,
    input  logic [CHAR_W-1:0] m_char_5,
    input  logic              m_out_of_range,
    input  logic              cfg_wr_en,
    input  logic [MODE_W-1:0] cfg_wr_data,
    output int                fail_count,
    output int                pending
);

    // six display characters, leftmost at index 0, plus the overflow flag
    typedef struct packed {
        logic [0:5][CHAR_W-1:0] chars;
        logic                   oor;
    } display_t;

    logic [MODE_W-1:0] shadow_mode;
    display_t          expected_displays[$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    // one printed line per mismatch
    task automatic report_mismatch(input string what);
        fail_count++;
        $display("%0t display_checker: %s", $time, what);
    endtask

    function automatic logic [CHAR_W-1:0] ascii_digit(input int unsigned d);
        return CH_ZERO + CHAR_W'(d);
    endfunction

    // asterisk pattern; the signed layout keeps its sign place blank
    function automatic display_t star_pattern(input logic signed_form);
        display_t r;
        if (signed_form) begin
            r.chars = {CH_SPACE, CH_STAR, CH_DOT, CH_STAR, CH_STAR, CH_STAR};
        end else begin
            r.chars = {CH_STAR, CH_STAR, CH_STAR, CH_DOT, CH_STAR, CH_STAR};
        end
        r.oor = 1'b1;
        return r;
    endfunction

    // expected display for one word in the given mode
    function automatic display_t format_display(input logic [MODE_W-1:0] mode,
                                                input logic [31:0] word);
        display_t    r;
        int unsigned n;
        int unsigned mag;
        int unsigned ip;
        int unsigned fb;
        int unsigned fr;
        logic        neg;
        n     = word;
        r.oor = 1'b0;
        case (mode)
            FMT_UDEC2: begin
                if (n > 99999) begin
                    r = star_pattern(1'b0);
                end else begin
                    r.chars[0] = (n < 10000) ? CH_SPACE : ascii_digit(n / 10000);
                    r.chars[1] = (n < 1000) ? CH_SPACE : ascii_digit((n / 1000) % 10);
                    r.chars[2] = ascii_digit((n / 100) % 10);
                    r.chars[3] = CH_DOT;
                    r.chars[4] = ascii_digit((n / 10) % 10);
                    r.chars[5] = ascii_digit(n % 10);
                end
            end
            FMT_SDEC3: begin
                neg = word[31];
                mag = neg ? (~word + 32'd1) : word;
                if (mag > 9999) begin
                    r = star_pattern(1'b1);
                end else begin
                    r.chars[0] = neg ? CH_MINUS : CH_SPACE;
                    r.chars[1] = ascii_digit(mag / 1000);
                    r.chars[2] = CH_DOT;
                    r.chars[3] = ascii_digit((mag / 100) % 10);
                    r.chars[4] = ascii_digit((mag / 10) % 10);
                    r.chars[5] = ascii_digit(mag % 10);
                end
            end
            // binary format, also taken by the unused mode code
            default: begin
                if (n > 255999) begin
                    r = star_pattern(1'b0);
                end else begin
                    ip = n / 256;
                    fb = n & 32'hFF;
                    if (fb == 255) begin
                        fb = 254;
                    end
                    fr = (fb * 25) / 64;
                    r.chars[0] = (ip >= 100) ? ascii_digit(ip / 100) : CH_SPACE;
                    r.chars[1] = (ip >= 10) ? ascii_digit((ip / 10) % 10) : CH_SPACE;
                    r.chars[2] = ascii_digit(ip % 10);
                    r.chars[3] = CH_DOT;
                    r.chars[4] = ascii_digit(fr / 10);
                    r.chars[5] = ascii_digit(fr % 10);
                end
            end
        endcase
        return r;
    endfunction

    // track the mode, queue a prediction per request, check each result
    always @(posedge aclk) begin : track_and_check
        display_t got;
        display_t want;
        if (!aresetn) begin
            shadow_mode = FMT_UDEC2;
            expected_displays.delete();
        end else begin
            if (cfg_wr_en) begin
                shadow_mode = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                expected_displays.push_back(format_display(shadow_mode, s_value_word));
            end
            if (m_valid && m_ready) begin
                got.chars = {m_char_0, m_char_1, m_char_2, m_char_3, m_char_4, m_char_5};
                got.oor   = m_out_of_range;
                if (expected_displays.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = expected_displays.pop_front();
                    for (int k = 0; k < 6; k++) begin
                        if (got.chars[k] !== want.chars[k]) begin
                            report_mismatch($sformatf("char_%0d got %h (%c) want %h (%c)",
                                k, got.chars[k], got.chars[k],
                                want.chars[k], want.chars[k]));
                        end
                    end
                    if (got.oor !== want.oor) begin
                        report_mismatch($sformatf("out_of_range got %b want %b",
                            got.oor, want.oor));
                    end
                end
            end
        end
        pending = expected_displays.size();
    end

endmodule

@@ test/testbench.sv @@
// top of the formatter testbench: clock, reset, stimulus, receiver and verdict
`timescale 1ns / 100ps
module testbench;
    import fpaf_pkg::*;

    // unused mode code, expected to act as the binary format
    localparam logic [MODE_W-1:0] FMT_SPARE = 2'd3;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [31:0]       s_value_word;
    logic              m_valid;
    logic              m_ready;
    logic [CHAR_W-1:0] m_char_0;
    logic [CHAR_W-1:0] m_char_1;
    logic [CHAR_W-1:0] m_char_2;
    logic [CHAR_W-1:0] m_char_3;
    logic [CHAR_W-1:0] m_char_4;
    logic [CHAR_W-1:0] m_char_5;
    logic              m_out_of_range;
    logic              cfg_wr_en;
    logic [MODE_W-1:0] cfg_wr_data;
    int                fail_count;
    int                pending;

    bit steady;
    int words_sent;

    fixed_point_ascii_formatter u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value_word   (s_value_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_char_0       (m_char_0),
        .m_char_1       (m_char_1),
        .m_char_2       (m_char_2),
        .m_char_3       (m_char_3),
        .m_char_4       (m_char_4),
        .m_char_5       (m_char_5),
        .m_out_of_range (m_out_of_range),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    display_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value_word   (s_value_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_char_0       (m_char_0),
        .m_char_1       (m_char_1),
        .m_char_2       (m_char_2),
        .m_char_3       (m_char_3),
        .m_char_4       (m_char_4),
        .m_char_5       (m_char_5),
        .m_out_of_range (m_out_of_range),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #1_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // receiver: random stalls outside the steady phase, one long hold-off once 200 words are sent
    initial begin : receiver
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (!hold_done && words_sent >= 200) begin
                hold_done = 1'b1;
                hold_left = 80;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (steady) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 35);
            end
        end
    end

    // offer one request, with a random gap first, and wait for its handshake
    task automatic send_word(input logic [31:0] word);
        bit taken;
        while (!steady && $urandom_range(0, 99) < 35) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_value_word <= word;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end
        words_sent++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        @(posedge aclk);
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] mode);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // random word: mostly in range for the mode, some near the limit, some raw
    function automatic logic [31:0] pick_word(input logic [MODE_W-1:0] mode);
        int unsigned kind;
        logic [31:0] w;
        kind = $urandom_range(0, 9);
        if (kind >= 8) begin
            w = $urandom;
        end else if (kind >= 6) begin
            case (mode)
                FMT_UDEC2: w = UDEC2_MAX - 3 + $urandom_range(0, 6);
                FMT_SDEC3: begin
                    w = SDEC3_MAX - 3 + $urandom_range(0, 6);
                    if ($urandom_range(0, 1)) begin
                        w = ~w + 32'd1;
                    end
                end
                default:   w = UBIN8_MAX - 3 + $urandom_range(0, 6);
            endcase
        end else begin
            case (mode)
                FMT_UDEC2: w = (kind == 0) ? $urandom_range(0, 999) : $urandom_range(0, 99999);
                FMT_SDEC3: begin
                    w = (kind == 0) ? $urandom_range(0, 999) : $urandom_range(0, 9999);
                    if ($urandom_range(0, 1)) begin
                        w = ~w + 32'd1;
                    end
                end
                default:   w = (kind == 0) ? $urandom_range(0, 25599)
                                           : $urandom_range(0, 255999);
            endcase
        end
        return w;
    endfunction

    // edge values for each format
    task automatic send_directed(input logic [MODE_W-1:0] mode);
        case (mode)
            FMT_UDEC2: begin
                send_word(32'd0);
                send_word(32'd99);
                send_word(32'd999);
                send_word(32'd1000);
                send_word(UDEC2_MAX);
                send_word(UDEC2_MAX + 1);
                send_word(32'hFFFF_FFFF);
            end
            FMT_SDEC3: begin
                send_word(32'd0);
                send_word(SDEC3_MAX);
                send_word(~SDEC3_MAX + 32'd1);
                send_word(SDEC3_MAX + 1);
                send_word(~SDEC3_MAX);
                send_word(32'h8000_0000);
                send_word(32'h7FFF_FFFF);
            end
            FMT_UBIN8: begin
                send_word(32'h0000_00FF);
                send_word(32'h0000_01FF);
                send_word(32'd2560);
                send_word(32'd25600);
                send_word(UBIN8_MAX);
                send_word(UBIN8_MAX + 1);
            end
            default: begin
                send_word(32'h0000_03FF);
                send_word(32'hFFFF_FFFF);
            end
        endcase
    endtask

    // stimulus: one phase per mode setting, idle between phases for the write
    initial begin : stimulus
        logic [MODE_W-1:0] phase_modes [7];
        phase_modes = '{FMT_UDEC2, FMT_SDEC3, FMT_UBIN8, FMT_SPARE,
                        FMT_UBIN8, FMT_SDEC3, FMT_UDEC2};
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_value_word = 32'd0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = FMT_UDEC2;
        steady       = 1'b0;
        words_sent   = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int p = 0; p < 7; p++) begin
            steady = (p == 4);
            write_mode(phase_modes[p]);
            if (p < 4) begin
                send_directed(phase_modes[p]);
            end
            repeat (118) send_word(pick_word(phase_modes[p]));
            wait_drained();
        end
        steady = 1'b0;
        repeat (25) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
